// ===== rtl/core/rsv_pkg.sv =====
// shared types and constants of the rtp sequence validator
`default_nettype none
package rsv_pkg;

  localparam int SeqW   = 16;
  localparam int SlotW  = 4;
  localparam int CfgW   = 16;
  localparam int RegIdxW = 2;

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_PACKET = 1'b1;

  localparam logic [RegIdxW-1:0] REG_DROP_LIMIT    = 2'd0;
  localparam logic [RegIdxW-1:0] REG_REORDER_LIMIT = 2'd1;
  localparam logic [RegIdxW-1:0] REG_SEQ_NEEDED    = 2'd2;

  localparam logic [15:0] DROP_LIMIT_RESET    = 16'd3000;
  localparam logic [15:0] REORDER_LIMIT_RESET = 16'd100;
  localparam logic [7:0]  SEQ_NEEDED_RESET    = 8'd2;
  localparam logic [16:0] PENDING_RESET       = 17'h10001;
  localparam logic [16:0] SEQ_SPAN            = 17'h10000;

  typedef struct packed {
    logic             command;
    logic [SlotW-1:0] slot;
    logic [SeqW-1:0]  seq;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] extended_highest;
    logic [31:0] received_count;
    logic        in_probation;
  } out_t;

  typedef struct packed {
    logic [15:0] highest_seq;
    logic [16:0] pending_bad;
    logic [15:0] wrap_count;
    logic [31:0] packets_counted;
    logic [7:0]  probation_left;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    highest_seq:     16'd0,
    pending_bad:     PENDING_RESET,
    wrap_count:      16'd0,
    packets_counted: 32'd0,
    probation_left:  8'd0
  };

  typedef struct packed {
    logic capture;
    logic exec;
  } ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/rsv_ram.sv =====
// generic single-port-write ram with registered read
`default_nettype none
module rsv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/rsv_ctrl.sv =====
// controller state machine of the rtp sequence validator
`default_nettype none
module rsv_ctrl
  import rsv_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  output ctl_t      ctl
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy        = (state == ST_EXEC);
  assign ctl.capture = start && (state == ST_IDLE);
  assign ctl.exec    = (state == ST_EXEC);

endmodule
`default_nettype wire

// ===== rtl/core/rsv_datapath.sv =====
// slot table, config registers and validation update
`default_nettype none
module rsv_datapath
  import rsv_pkg::*;
#(
  parameter int SOURCES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ctl_t               ctl,
  input  wire in_t                request,
  input  wire logic               cfg_we,
  input  wire logic [RegIdxW-1:0] cfg_index,
  input  wire logic [CfgW-1:0]    cfg_data,
  output logic                    done,
  output out_t                    response
);

  localparam int MaxSlots = 1 << SlotW;
  localparam int Depth    = (SOURCES < MaxSlots) ? SOURCES : MaxSlots;
  localparam int AW       = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int EW       = $bits(entry_t);

  logic [15:0] drop_limit;
  logic [15:0] reorder_limit;
  logic [7:0]  seq_needed;

  in_t              req;
  logic             hit;
  logic             in_range;
  logic [Depth-1:0] valid;
  logic [EW-1:0]    rdata;
  logic             wr_en;
  entry_t           upd;
  logic             ok;
  entry_t           cur;

  logic [15:0] udelta;
  logic [7:0]  prob_dec;
  logic [16:0] dist_sum;

  wire logic [AW-1:0] raddr = request.slot[AW-1:0];
  wire logic [AW-1:0] waddr = req.slot[AW-1:0];

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      drop_limit    <= DROP_LIMIT_RESET;
      reorder_limit <= REORDER_LIMIT_RESET;
      seq_needed    <= SEQ_NEEDED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DROP_LIMIT:    drop_limit    <= cfg_data;
        REG_REORDER_LIMIT: reorder_limit <= cfg_data;
        REG_SEQ_NEEDED:    seq_needed    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      req <= request;
      hit <= valid[raddr];
    end
  end

  rsv_ram #(.WIDTH(EW), .DEPTH(Depth)) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (upd),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_range = ({1'b0, req.slot} < (SlotW + 1)'(Depth));
  assign wr_en    = ctl.exec && in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[waddr] <= 1'b1;
    end
  end

  // validation rule
  always_comb begin
    if (req.command == CMD_START) begin
      cur                 = ENTRY_RESET;
      cur.highest_seq     = req.seq - 16'd1;
      cur.probation_left  = seq_needed;
    end else if (hit) begin
      cur = entry_t'(rdata);
    end else begin
      cur = ENTRY_RESET;
    end

    udelta   = req.seq - cur.highest_seq;
    prob_dec = cur.probation_left - 8'd1;
    dist_sum = {1'b0, udelta} + {1'b0, reorder_limit};
    upd      = cur;
    ok       = 1'b0;

    if (cur.probation_left != 8'd0) begin
      upd.highest_seq = req.seq;
      if ({1'b0, req.seq} == {1'b0, cur.highest_seq} + 17'd1) begin
        upd.probation_left = prob_dec;
        if (prob_dec == 8'd0) begin
          upd.pending_bad     = PENDING_RESET;
          upd.wrap_count      = 16'd0;
          upd.packets_counted = 32'd1;
          ok                  = 1'b1;
        end
      end else begin
        upd.probation_left = seq_needed - 8'd1;
      end
    end else if (udelta < drop_limit) begin
      if (req.seq < cur.highest_seq) upd.wrap_count = cur.wrap_count + 16'd1;
      upd.highest_seq     = req.seq;
      upd.packets_counted = cur.packets_counted + 32'd1;
      ok                  = 1'b1;
    end else if (dist_sum <= SEQ_SPAN) begin
      if ({1'b0, req.seq} == cur.pending_bad) begin
        upd.highest_seq     = req.seq;
        upd.pending_bad     = PENDING_RESET;
        upd.wrap_count      = 16'd0;
        upd.packets_counted = 32'd1;
        ok                  = 1'b1;
      end else begin
        upd.pending_bad = {1'b0, req.seq + 16'd1};
      end
    end else begin
      upd.packets_counted = cur.packets_counted + 32'd1;
      ok                  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      if (in_range) begin
        response.accepted         <= ok;
        response.extended_highest <= {upd.wrap_count, upd.highest_seq};
        response.received_count   <= upd.packets_counted;
        response.in_probation     <= (upd.probation_left != 8'd0);
      end else begin
        response <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rtp_sequence_validator_core.sv =====
// top level of the rtp sequence validator
//
//  port group                      direction  transfer condition
//  start / request                 in         start && !busy at clk edge
//  done / response                 out        done high for one cycle
//  cfg_we / cfg_index / cfg_data   in         cfg_we high at clk edge
//
//  for a request the slot entry is first read from the table ram,
//  then updated and written back while the result is registered
//  busy is high in the update cycle; a new request can start the cycle after
//  done rises in the cycle after the update and cannot be stalled
//  synchronous reset restores config defaults and marks all slots empty
`default_nettype none
module rtp_sequence_validator_core
  import rsv_pkg::*;
#(
  parameter int SOURCES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire in_t                request,
  output logic                    done,
  output out_t                    response,
  input  wire logic               cfg_we,
  input  wire logic [RegIdxW-1:0] cfg_index,
  input  wire logic [CfgW-1:0]    cfg_data
);

  ctl_t ctl;

  rsv_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .ctl   (ctl)
  );

  rsv_datapath #(.SOURCES(SOURCES)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .request   (request),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .response  (response)
  );

endmodule
`default_nettype wire
